/* hdl/isort_pkg.sv */
// ----------------------------------------------------------------------------
// isort_pkg: shared types and constants for the insertion sorter
// Holds the request and result payload types, the cell link types and the
// cell operation codes used by the sorting chain.
// ----------------------------------------------------------------------------
package isort_pkg;

    // Width of a sorted value and of the output rank.
    localparam int VALUE_W = 32;
    localparam int RANK_W  = 5;

    // One incoming request.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      final_item;
    } request_t;

    // One outgoing result.
    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic [RANK_W-1:0]         rank;
        logic                      last_of_run;
        logic                      overflowed;
    } result_t;

    // Operation applied to every cell of the chain in the same cycle.
    typedef enum logic [1:0] {
        CELL_HOLD     = 2'd0,
        CELL_INSERT   = 2'd1,
        CELL_SHIFT_DN = 2'd2,
        CELL_SHIFT_UP = 2'd3
    } cell_op_t;

    // Broadcast control shared by all cells.
    typedef struct packed {
        cell_op_t                  op;
        logic signed [VALUE_W-1:0] new_value;
    } cell_ctrl_t;

    // What a cell shows to its neighbors.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      valid;
        logic                      greater;
    } cell_link_t;

endpackage

/* hdl/isort_cell.sv */
// ----------------------------------------------------------------------------
// isort_cell: one cell of the insertion chain
// Holds one stored value. On an insert it keeps its value, takes the new value
// or takes its lower neighbor's value; on a drain it shifts one place.
// ----------------------------------------------------------------------------
module isort_cell
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  isort_pkg::cell_ctrl_t  ctrl,
    input  isort_pkg::cell_link_t  lower,
    input  isort_pkg::cell_link_t  upper,
    output isort_pkg::cell_link_t  link
);

    logic signed [isort_pkg::VALUE_W-1:0] value_reg;
    logic signed [isort_pkg::VALUE_W-1:0] value_next;
    logic                                 valid_reg;
    logic                                 valid_next;
    logic                                 greater;

    // An empty cell or one holding a larger value makes room for the new one.
    assign greater = !valid_reg || (value_reg > ctrl.new_value);

    assign link.value   = value_reg;
    assign link.valid   = valid_reg;
    assign link.greater = greater;

    // Next contents of the cell.
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            isort_pkg::CELL_INSERT:
            begin
                if (greater)
                begin
                    if (lower.greater)
                    begin
                        value_next = lower.value;
                        valid_next = lower.valid;
                    end
                    else
                    begin
                        value_next = ctrl.new_value;
                        valid_next = 1'b1;
                    end
                end
            end
            isort_pkg::CELL_SHIFT_DN:
            begin
                value_next = upper.value;
                valid_next = upper.valid;
            end
            isort_pkg::CELL_SHIFT_UP:
            begin
                value_next = lower.value;
                valid_next = lower.valid;
            end
            default:
            begin
                value_next = value_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Valid flag is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stored value needs no reset.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* hdl/insertion_sorter.sv */
// ----------------------------------------------------------------------------
// insertion_sorter: sorts a run of signed values in a chain of cells
// Values are inserted one per cycle, unless busy, into a chain of DEPTH cells
// that is kept in ascending order; the marked final value triggers read-out.
// ----------------------------------------------------------------------------
// Usage:
//   A request (value, final_item) is taken at a rising edge with start high
//   and busy low. Every cell compares the new value in parallel, so after a
//   non-final request the next request can follow immediately.
//   Once DEPTH values are held, further values of the run are dropped and
//   the overflowed flag is set on that run's results.
//   The final request raises busy. In ascending order the chain shifts toward
//   cell 0 and one result leaves per cycle, the first registered from cell 0
//   in the drain state after the final request. In descending order the
//   chain shifts toward the top cell, which first passes on the empty cells
//   above the run before any result leaves. busy falls with the last result.
//   Each result is shown for one cycle under result_valid; the receiver
//   cannot stall. cfg_we/cfg_wdata write the descending register, which is
//   sampled on the final request. Reset empties the chain, clears the drop
//   flag and selects ascending order.
// ----------------------------------------------------------------------------
module insertion_sorter
#(
    parameter int DEPTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  isort_pkg::request_t   item,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    output logic                  result_valid,
    output isort_pkg::result_t    result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         fill_count_reg, fill_count_next;
    logic [CNT_W-1:0]         remaining_reg, remaining_next;
    logic [isort_pkg::RANK_W-1:0] rank_reg, rank_next;
    logic                     drop_reg, drop_next;
    logic                     overflow_reg, overflow_next;
    logic                     descending_reg, descending_next;
    logic                     dir_reg, dir_next;
    logic                     result_valid_reg, result_valid_next;
    isort_pkg::result_t       result_reg, result_next;

    isort_pkg::cell_ctrl_t    ctrl;
    isort_pkg::cell_link_t    links [DEPTH];
    isort_pkg::cell_link_t    tail;
    logic                     accept;
    logic                     full;

    assign busy         = (state_reg == ST_DRAIN);
    assign accept       = start && !busy;
    assign full         = (fill_count_reg == CNT_W'(DEPTH));
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Cell that leaves the chain on a drain cycle.
    assign tail = dir_reg ? links[DEPTH-1] : links[0];

    // Chain of cells.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        isort_pkg::cell_link_t lower;
        isort_pkg::cell_link_t upper;
        if (i == 0)
        begin : g_bottom
            assign lower = '0;
        end
        else
        begin : g_lower
            assign lower = links[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_upper
            assign upper = links[i+1];
        end
        isort_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .lower (lower),
            .upper (upper),
            .link  (links[i])
        );
    end

    // Sequencer: insertion while idle, one shift per cycle while draining.
    always_comb
    begin
        state_next        = state_reg;
        fill_count_next   = fill_count_reg;
        remaining_next    = remaining_reg;
        rank_next         = rank_reg;
        drop_next         = drop_reg;
        overflow_next     = overflow_reg;
        dir_next          = dir_reg;
        descending_next   = cfg_we ? cfg_wdata : descending_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        ctrl.op           = isort_pkg::CELL_HOLD;
        ctrl.new_value    = item.value;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.op         = isort_pkg::CELL_INSERT;
                        fill_count_next = fill_count_reg + CNT_W'(1);
                    end
                    if (item.final_item)
                    begin
                        state_next      = ST_DRAIN;
                        remaining_next  = full ? fill_count_reg
                                               : fill_count_reg + CNT_W'(1);
                        overflow_next   = drop_reg || full;
                        drop_next       = 1'b0;
                        fill_count_next = '0;
                        dir_next        = descending_reg;
                        rank_next       = '0;
                    end
                end
            end
            ST_DRAIN:
            begin
                ctrl.op = dir_reg ? isort_pkg::CELL_SHIFT_UP : isort_pkg::CELL_SHIFT_DN;
                if (tail.valid)
                begin
                    result_valid_next        = 1'b1;
                    result_next.sorted_value = tail.value;
                    result_next.rank         = rank_reg;
                    result_next.last_of_run  = (remaining_reg == CNT_W'(1));
                    result_next.overflowed   = overflow_reg;
                    rank_next                = rank_reg + isort_pkg::RANK_W'(1);
                    remaining_next           = remaining_reg - CNT_W'(1);
                    if (remaining_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fill_count_reg   <= '0;
            remaining_reg    <= '0;
            rank_reg         <= '0;
            drop_reg         <= 1'b0;
            overflow_reg     <= 1'b0;
            descending_reg   <= 1'b0;
            dir_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_count_reg   <= fill_count_next;
            remaining_reg    <= remaining_next;
            rank_reg         <= rank_next;
            drop_reg         <= drop_next;
            overflow_reg     <= overflow_next;
            descending_reg   <= descending_next;
            dir_reg          <= dir_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule
